### rtl/lrusc_pkg.sv
package lrusc_pkg;

	// Table geometry.
	localparam int SLOTS    = 8;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	// Widths of the result fields on the ports.
	localparam int SLOT_W   = 3;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 4;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    rank_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// Access outcome codes.
	localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNAV  = 2'd3;

	// Outcome of one compare step over one slot.
	typedef struct packed {
		logic match;
		logic older;
	} cmp_res_t;

endpackage

### rtl/lrusc_cmp.sv
module lrusc_cmp import lrusc_pkg::*; (
	input  key_t     req_key,
	input  key_t     slot_key,
	input  rank_t    slot_rank,
	input  rank_t    best_rank,
	input  logic     first,
	output cmp_res_t res
);

	// Key match for the lookup, and the running oldest-slot test for eviction.
	// The first slot always seeds the oldest candidate.
	always_comb begin
		res.match = (req_key == slot_key);
		res.older = first || (slot_rank > best_rank);
	end

endmodule

### rtl/lru_slot_cache_policy.sv
// Each access is accepted, scans N slots, then updates the table and posts its result, where N
// is the number of slots scanned (1 to 8; a hit stops the scan early, an empty table skips it).
// The block takes one item at a time: a new item is not accepted until the last one is done.
// The scan steps the shared key/rank compare unit over the slots, one slot per cycle.
// Reset clears the occupied count and the control state; slot keys and ranks stay
// undefined until written.
module lru_slot_cache_policy import lrusc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         table_key,
	input  logic                source_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SLOT_W-1:0]   slot,
	output logic [STATUS_W-1:0] status,
	output logic [15:0]         evicted_key,
	output logic [OCC_W-1:0]    occupied_count
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;

	logic [1:0] state_q;
	cnt_t       idx_q;
	cnt_t       used_q;
	key_t       req_key_q;
	logic       present_q;
	logic       hit_q;
	idx_t       hit_idx_q;
	rank_t      hit_rank_q;
	idx_t       best_idx_q;
	rank_t      best_rank_q;
	key_t       best_key_q;

	key_t  keys_q  [SLOTS];
	rank_t ranks_q [SLOTS];

	logic                out_valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [STATUS_W-1:0] status_q;
	logic [15:0]         evicted_q;
	logic [OCC_W-1:0]    occ_q;

	cmp_res_t cmp;
	idx_t     scan_idx;

	logic                upd_go;
	logic                upd_write;
	logic                upd_age;
	idx_t                upd_slot;
	cnt_t                upd_limit;
	cnt_t                upd_used;
	logic [STATUS_W-1:0] upd_status;
	key_t                upd_evicted;

	assign scan_idx = idx_q[IDX_W-1:0];
	assign in_stall = (state_q != S_IDLE);
	assign upd_go   = (state_q == S_UPDATE) && (!out_valid_q || !out_stall);

	// Shared compare unit, stepped over the slots by the scan counter.
	lrusc_cmp u_cmp (
		.req_key   (req_key_q),
		.slot_key  (keys_q[scan_idx]),
		.slot_rank (ranks_q[scan_idx]),
		.best_rank (best_rank_q),
		.first     (idx_q == '0),
		.res       (cmp)
	);

	// Decide the outcome of the access once the scan is done.
	always_comb begin
		upd_write   = 1'b0;
		upd_age     = 1'b0;
		upd_slot    = '0;
		upd_limit   = '0;
		upd_used    = used_q;
		upd_status  = ST_UNAV;
		upd_evicted = '0;
		if (hit_q) begin
			upd_age    = 1'b1;
			upd_slot   = hit_idx_q;
			upd_limit  = cnt_t'(hit_rank_q);
			upd_status = ST_HIT;
		end else if (!present_q) begin
			upd_status = ST_UNAV;
		end else if (used_q < cnt_t'(SLOTS)) begin
			upd_write  = 1'b1;
			upd_age    = 1'b1;
			upd_slot   = used_q[IDX_W-1:0];
			upd_limit  = cnt_t'(SLOTS);
			upd_used   = used_q + cnt_t'(1);
			upd_status = ST_FILL;
		end else begin
			upd_write   = 1'b1;
			upd_age     = 1'b1;
			upd_slot    = best_idx_q;
			upd_limit   = cnt_t'(best_rank_q);
			upd_status  = ST_EVICT;
			upd_evicted = best_key_q;
		end
	end

	// Sequencer: accept, scan one slot per cycle, then update and post the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result raises valid; a taken result with nothing behind it drops it.
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (used_q == '0) ? S_UPDATE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp.match || (idx_q + cnt_t'(1) == used_q)) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_go) begin
						used_q  <= upd_used;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_key_q <= table_key[KEY_BITS-1:0];
			present_q <= source_present;
			idx_q     <= '0;
			hit_q     <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (cmp.match) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= scan_idx;
				hit_rank_q <= ranks_q[scan_idx];
			end else begin
				if (cmp.older) begin
					best_idx_q  <= scan_idx;
					best_rank_q <= ranks_q[scan_idx];
					best_key_q  <= keys_q[scan_idx];
				end
				idx_q <= idx_q + cnt_t'(1);
			end
		end
	end

	// Slot store: at most one key write per access, ranks aged in place.
	always_ff @(posedge clk) begin
		if (upd_go && upd_write) begin
			keys_q[upd_slot] <= req_key_q;
		end
		if (upd_go && upd_age) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (idx_t'(i) == upd_slot) begin
					ranks_q[i] <= '0;
				end else if ((cnt_t'(i) < upd_used) &&
						(cnt_t'(ranks_q[i]) < upd_limit)) begin
					ranks_q[i] <= ranks_q[i] + rank_t'(1);
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (upd_go) begin
			slot_q    <= SLOT_W'(upd_slot);
			status_q  <= upd_status;
			evicted_q <= 16'(upd_evicted);
			occ_q     <= OCC_W'(upd_used);
		end
	end

	assign out_valid      = out_valid_q;
	assign slot           = slot_q;
	assign status         = status_q;
	assign evicted_key    = evicted_q;
	assign occupied_count = occ_q;

	// The occupied count never shrinks and never passes the table size.
	a_used_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (used_q >= $past(used_q)) && (used_q <= cnt_t'(SLOTS)))
		else $error("occupied count shrank or overflowed");

	// Only an eviction reports a removed key.
	a_evict_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_EVICT) |-> (evicted_key == '0))
		else $error("removed key reported without eviction");

	// An unavailable source reports slot zero and leaves the count alone.
	a_unav: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && upd_status == ST_UNAV) |=> (slot == '0) && $stable(used_q))
		else $error("unavailable access changed state");

	// A fill lands only when the table still has room and raises the count by one.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && upd_status == ST_FILL) |=> (used_q == $past(used_q) + cnt_t'(1)))
		else $error("fill did not advance occupied count");

endmodule
